FILE: rtl/tlwm_pkg.sv
package tlwm_pkg;

    // Event codes carried on the input tuser field.
    localparam logic [2:0] MODE_ARM     = 3'd0;
    localparam logic [2:0] MODE_DISARM  = 3'd1;
    localparam logic [2:0] MODE_STARTED = 3'd2;
    localparam logic [2:0] MODE_REACHED = 3'd3;
    localparam logic [2:0] MODE_TICK    = 3'd4;
    localparam logic [2:0] MODE_ERROR   = 3'd5;

    // Monitor state codes.
    localparam logic [1:0] ST_WAIT = 2'd0;
    localparam logic [1:0] ST_MON  = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    // Motor direction codes; any other value checks both sides.
    localparam logic [1:0] DIR_UP   = 2'd0;
    localparam logic [1:0] DIR_DOWN = 2'd1;

    // Endstop floors.
    localparam logic [3:0] FLOOR_BOTTOM = 4'd0;
    localparam logic [3:0] FLOOR_TOP    = 4'd1;

    localparam logic [15:0] TOLERANCE_RESET = 16'd15;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] position;
        logic [3:0]         floor;
        logic [1:0]         direction;
    } item_t;

    typedef struct packed {
        logic [1:0] monitor_state;
        logic       issue_raised;
        logic       limits_locked;
        logic       checking;
    } result_t;

    typedef struct packed {
        logic               locked;
        logic signed [31:0] lower_limit;
        logic signed [31:0] upper_limit;
        logic [15:0]        tolerance;
    } window_t;

endpackage

FILE: rtl/travel_limit_window_monitor_top.sv
// Travel limit window monitor. Each input transaction is one lift event (arm,
// disarm, started moving, reached floor, check tick, error) and produces exactly
// one output transaction reporting the monitor state, a one-shot issue pulse,
// whether the travel limits are locked and whether periodic checks are enabled.
// The first arrivals at floor 0 and floor 1 capture the encoder position; when
// both captures exist and differ they are sorted and locked as the lower and
// upper limits. A check tick while monitoring compares the position against the
// limits widened by position_tolerance (upward checks the upper side, downward
// the lower side, anything else both), in 33-bit arithmetic so no sum overflows.
// A lift error latches until the block is disarmed and armed again.
// Timing: the event first lands in an input register, and once the output
// register is free the state update and limit compare run in one pass into
// the output register; one transaction is accepted every cycle as long as
// the output side keeps taking results. The output register and the input
// register together form a two-entry pipeline, so while a result waits on
// tready one more event can still be accepted into an empty input register.
// The tolerance register resets to 15 and is written through the cfg channel,
// which is always ready; write it only while no event is in flight.
module travel_limit_window_monitor_top (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write: position_tolerance.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    // Event input.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: position [31:0], floor [35:32], direction [37:36], zero [39:38].
    input  logic [39:0] s_axis_tdata,
    // tuser: mode [2:0].
    input  logic [2:0]  s_axis_tuser,
    // Result output.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: monitor_state [1:0], issue_raised [2], limits_locked [3],
    // checking [4], zero [7:5].
    output logic [7:0]  m_axis_tdata
);

    logic              in_valid_reg;
    tlwm_pkg::item_t   in_item_reg;
    logic              out_valid_reg;
    tlwm_pkg::result_t out_result_reg;
    logic [15:0]       tolerance_reg;
    logic              advance;
    tlwm_pkg::result_t result;

    // The held event moves into the output register whenever that register
    // is empty or is being emptied this cycle.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg <= tlwm_pkg::TOLERANCE_RESET;
        end
        else if (cfg_valid)
        begin
            tolerance_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg <= '{mode: s_axis_tuser,
                             position: s_axis_tdata[31:0],
                             floor: s_axis_tdata[35:32],
                             direction: s_axis_tdata[37:36]};
        end
    end

    tlwm_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (advance),
        .item       (in_item_reg),
        .tolerance  (tolerance_reg),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'd0, out_result_reg.checking, out_result_reg.limits_locked,
                            out_result_reg.issue_raised, out_result_reg.monitor_state};

endmodule

FILE: rtl/tlwm_limit_check.sv
module tlwm_limit_check (
    input  tlwm_pkg::window_t  window,
    input  logic signed [31:0] position,
    input  logic [1:0]         direction,
    output logic               position_ok
);

    logic signed [32:0] pos_ext;
    logic signed [32:0] upper_bound;
    logic signed [32:0] lower_bound;
    logic               above;
    logic               below;

    // 33 bits hold any 32-bit limit widened by a 16-bit tolerance.
    assign pos_ext     = {position[31], position};
    assign upper_bound = {window.upper_limit[31], window.upper_limit}
                         + $signed({17'd0, window.tolerance});
    assign lower_bound = {window.lower_limit[31], window.lower_limit}
                         - $signed({17'd0, window.tolerance});
    assign above       = pos_ext > upper_bound;
    assign below       = pos_ext < lower_bound;

    always_comb
    begin
        if (!window.locked)
        begin
            position_ok = 1'b1;
        end
        else if (direction == tlwm_pkg::DIR_UP)
        begin
            position_ok = !above;
        end
        else if (direction == tlwm_pkg::DIR_DOWN)
        begin
            position_ok = !below;
        end
        else
        begin
            position_ok = !(above || below);
        end
    end

endmodule

FILE: rtl/tlwm_core.sv
module tlwm_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  tlwm_pkg::item_t     item,
    input  logic [15:0]         tolerance,
    output tlwm_pkg::result_t   result
);

    logic [1:0]         state_reg, state_next;
    logic               armed_reg, armed_next;
    logic               notified_reg, notified_next;
    logic               check_en_reg, check_en_next;
    logic               bottom_seen_reg, bottom_seen_next;
    logic               top_seen_reg, top_seen_next;
    logic signed [31:0] bottom_cap_reg, bottom_cap_next;
    logic signed [31:0] top_cap_reg, top_cap_next;
    logic signed [31:0] lower_reg, lower_next;
    logic signed [31:0] upper_reg, upper_next;
    logic               locked_reg, locked_next;
    logic               pulse;
    logic               position_ok;
    tlwm_pkg::window_t  window;

    assign window = '{locked: locked_reg, lower_limit: lower_reg,
                      upper_limit: upper_reg, tolerance: tolerance};

    tlwm_limit_check u_limit_check (
        .window      (window),
        .position    (item.position),
        .direction   (item.direction),
        .position_ok (position_ok)
    );

    always_comb
    begin
        state_next       = state_reg;
        armed_next       = armed_reg;
        notified_next    = notified_reg;
        check_en_next    = check_en_reg;
        bottom_seen_next = bottom_seen_reg;
        top_seen_next    = top_seen_reg;
        bottom_cap_next  = bottom_cap_reg;
        top_cap_next     = top_cap_reg;
        lower_next       = lower_reg;
        upper_next       = upper_reg;
        locked_next      = locked_reg;
        pulse            = 1'b0;

        unique case (item.mode)
            tlwm_pkg::MODE_ARM:
            begin
                if (!armed_reg)
                begin
                    armed_next    = 1'b1;
                    notified_next = 1'b0;
                    state_next    = tlwm_pkg::ST_WAIT;
                end
            end
            tlwm_pkg::MODE_DISARM:
            begin
                if (armed_reg)
                begin
                    armed_next    = 1'b0;
                    check_en_next = 1'b0;
                end
            end
            tlwm_pkg::MODE_STARTED:
            begin
                if (state_reg == tlwm_pkg::ST_WAIT)
                begin
                    state_next = tlwm_pkg::ST_MON;
                end
                // Waiting and monitoring both end up monitoring here.
                if (locked_reg && armed_reg && !notified_reg &&
                    (state_reg == tlwm_pkg::ST_WAIT || state_reg == tlwm_pkg::ST_MON))
                begin
                    check_en_next = 1'b1;
                end
            end
            tlwm_pkg::MODE_REACHED:
            begin
                if (!locked_reg)
                begin
                    if (item.floor == tlwm_pkg::FLOOR_BOTTOM && !bottom_seen_reg)
                    begin
                        bottom_seen_next = 1'b1;
                        bottom_cap_next  = item.position;
                    end
                    else if (item.floor == tlwm_pkg::FLOOR_TOP && !top_seen_reg)
                    begin
                        top_seen_next = 1'b1;
                        top_cap_next  = item.position;
                    end
                    if (bottom_seen_next && top_seen_next)
                    begin
                        if (bottom_cap_next < top_cap_next)
                        begin
                            lower_next = bottom_cap_next;
                            upper_next = top_cap_next;
                        end
                        else
                        begin
                            lower_next = top_cap_next;
                            upper_next = bottom_cap_next;
                        end
                        // Equal captures never lock.
                        locked_next = bottom_cap_next != top_cap_next;
                    end
                end
                if (state_reg == tlwm_pkg::ST_MON)
                begin
                    state_next = tlwm_pkg::ST_WAIT;
                end
                check_en_next = 1'b0;
            end
            tlwm_pkg::MODE_TICK:
            begin
                if (check_en_reg && state_reg == tlwm_pkg::ST_MON && !notified_reg &&
                    !position_ok)
                begin
                    state_next    = tlwm_pkg::ST_ERR;
                    notified_next = 1'b1;
                    pulse         = 1'b1;
                end
            end
            tlwm_pkg::MODE_ERROR:
            begin
                if (state_reg == tlwm_pkg::ST_MON)
                begin
                    state_next = tlwm_pkg::ST_ERR;
                    if (!notified_reg)
                    begin
                        notified_next = 1'b1;
                        pulse         = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign result = '{monitor_state: state_next, issue_raised: pulse,
                      limits_locked: locked_next, checking: check_en_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= tlwm_pkg::ST_WAIT;
            armed_reg       <= 1'b0;
            notified_reg    <= 1'b0;
            check_en_reg    <= 1'b0;
            bottom_seen_reg <= 1'b0;
            top_seen_reg    <= 1'b0;
            bottom_cap_reg  <= '0;
            top_cap_reg     <= '0;
            lower_reg       <= '0;
            upper_reg       <= '0;
            locked_reg      <= 1'b0;
        end
        else if (item_valid)
        begin
            state_reg       <= state_next;
            armed_reg       <= armed_next;
            notified_reg    <= notified_next;
            check_en_reg    <= check_en_next;
            bottom_seen_reg <= bottom_seen_next;
            top_seen_reg    <= top_seen_next;
            bottom_cap_reg  <= bottom_cap_next;
            top_cap_reg     <= top_cap_next;
            lower_reg       <= lower_next;
            upper_reg       <= upper_next;
            locked_reg      <= locked_next;
        end
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the travel limit window monitor. A directed table walks the
// lift through its special cases, then random event streams run under several
// tolerance settings. Every accepted event is fed to a local model of the
// monitor, and every result transaction is compared field by field against the
// oldest expected report.
module tb_top;
    import tlwm_pkg::*;

    // Direction and event codes that the package leaves unnamed.
    localparam logic [1:0] DIR_UNKNOWN = 2'd2;
    localparam logic [1:0] DIR_SPARE   = 2'd3;
    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;

    localparam int PHASE_ITEMS  = 140;
    localparam int IDLE_PERCENT = 28;
    localparam int CYCLE_LIMIT  = 200000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;

    // When set, neither side inserts idle cycles.
    logic calm_stretch = 1'b0;
    int   fail_count = 0;
    int   cycle_count = 0;

    // Reports the block owes us, oldest first.
    result_t pending_reports[$];

    // Local copy of the monitor state and its tolerance register.
    logic [15:0]        tolerance;
    logic [1:0]         st_state;
    logic               st_armed;
    logic               st_notified;
    logic               st_check_en;
    logic               seen_bottom;
    logic               seen_top;
    logic signed [31:0] cap_bottom;
    logic signed [31:0] cap_top;
    logic signed [31:0] lim_lo;
    logic signed [31:0] lim_hi;
    logic               lim_locked;

    typedef struct {
        item_t   ev;
        bit      typed;
        result_t want;
    } stim_row_t;

    stim_row_t directed_rows[$];

    travel_limit_window_monitor_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one event to the local model and returns the report it causes.
    function automatic result_t advance_monitor(item_t ev);
        result_t    rep;
        logic       pulse;
        logic       out_of_window;
        logic [32:0] pos_w;
        logic [32:0] hi_edge;
        logic [32:0] lo_edge;
        pulse = 1'b0;
        out_of_window = 1'b0;
        case (ev.mode)
            MODE_ARM:
                if (!st_armed)
                begin
                    st_armed = 1'b1;
                    st_notified = 1'b0;
                    st_state = ST_WAIT;
                end
            MODE_DISARM:
                if (st_armed)
                begin
                    st_armed = 1'b0;
                    st_check_en = 1'b0;
                end
            MODE_STARTED:
            begin
                if (st_state == ST_WAIT)
                    st_state = ST_MON;
                if (lim_locked && st_state == ST_MON && st_armed && !st_notified)
                    st_check_en = 1'b1;
            end
            MODE_REACHED:
            begin
                // Captures are taken only once per endstop, and never after locking.
                if (!lim_locked)
                begin
                    if (ev.floor == FLOOR_BOTTOM && !seen_bottom)
                    begin
                        seen_bottom = 1'b1;
                        cap_bottom = ev.position;
                    end
                    else if (ev.floor == FLOOR_TOP && !seen_top)
                    begin
                        seen_top = 1'b1;
                        cap_top = ev.position;
                    end
                    if (seen_bottom && seen_top)
                    begin
                        if (cap_bottom < cap_top)
                        begin
                            lim_lo = cap_bottom;
                            lim_hi = cap_top;
                        end
                        else
                        begin
                            lim_lo = cap_top;
                            lim_hi = cap_bottom;
                        end
                        lim_locked = lim_lo < lim_hi;
                    end
                end
                if (st_state == ST_MON)
                    st_state = ST_WAIT;
                st_check_en = 1'b0;
            end
            MODE_TICK:
                // An unlocked window always counts as inside.
                if (st_check_en && st_state == ST_MON && !st_notified && lim_locked)
                begin
                    // 33-bit edges so the tolerance never wraps the limits.
                    pos_w = {ev.position[31], ev.position};
                    hi_edge = {lim_hi[31], lim_hi} + {17'd0, tolerance};
                    lo_edge = {lim_lo[31], lim_lo} - {17'd0, tolerance};
                    case (ev.direction)
                        DIR_UP:   out_of_window = $signed(pos_w) > $signed(hi_edge);
                        DIR_DOWN: out_of_window = $signed(pos_w) < $signed(lo_edge);
                        default:  out_of_window = $signed(pos_w) > $signed(hi_edge)
                                                  || $signed(pos_w) < $signed(lo_edge);
                    endcase
                    if (out_of_window)
                    begin
                        st_state = ST_ERR;
                        if (!st_notified)
                        begin
                            st_notified = 1'b1;
                            pulse = 1'b1;
                        end
                    end
                end
            MODE_ERROR:
                if (st_state == ST_MON)
                begin
                    st_state = ST_ERR;
                    if (!st_notified)
                    begin
                        st_notified = 1'b1;
                        pulse = 1'b1;
                    end
                end
            default:
                ;
        endcase
        rep.monitor_state = st_state;
        rep.issue_raised = pulse;
        rep.limits_locked = lim_locked;
        rep.checking = st_check_en;
        return rep;
    endfunction

    task automatic add_row(input logic [2:0] mode, input logic signed [31:0] pos,
                           input logic [3:0] flr, input logic [1:0] dir, input bit typed,
                           input logic [1:0] w_state, input logic w_issue,
                           input logic w_locked, input logic w_checking);
        stim_row_t row;
        row.ev.mode = mode;
        row.ev.position = pos;
        row.ev.floor = flr;
        row.ev.direction = dir;
        row.typed = typed;
        row.want.monitor_state = w_state;
        row.want.issue_raised = w_issue;
        row.want.limits_locked = w_locked;
        row.want.checking = w_checking;
        directed_rows.push_back(row);
    endtask

    // Positions cluster on both widened edges, with some fully random values.
    function automatic logic [31:0] tick_position();
        int     pick;
        longint offs;
        pick = $urandom_range(0, 99);
        offs = longint'($urandom_range(0, 6)) - 3;
        if (pick < 40)
            return 32'(longint'(lim_hi) + longint'(tolerance) + offs);
        else if (pick < 80)
            return 32'(longint'(lim_lo) - longint'(tolerance) + offs);
        return $urandom;
    endfunction

    // Mostly well-formed lift traffic; a latched error is steered toward
    // the disarm and re-arm that clears it.
    function automatic item_t pick_event();
        item_t ev;
        int    pick;
        ev.position = tick_position();
        ev.floor = 4'($urandom_range(0, 15));
        ev.direction = 2'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (st_state == ST_ERR && pick < 60)
            ev.mode = (pick < 30) ? MODE_DISARM : MODE_ARM;
        else if (pick < 48)
            ev.mode = MODE_TICK;
        else if (pick < 60)
            ev.mode = MODE_STARTED;
        else if (pick < 70)
            ev.mode = MODE_REACHED;
        else if (pick < 78)
            ev.mode = MODE_ARM;
        else if (pick < 84)
            ev.mode = MODE_DISARM;
        else if (pick < 90)
            ev.mode = MODE_ERROR;
        else if (pick < 93)
            ev.mode = ($urandom_range(0, 1) == 0) ? MODE_SPARE6 : MODE_SPARE7;
        else
            ev.mode = 3'($urandom_range(0, 7));
        return ev;
    endfunction

    // Presents one event, holding tvalid through backpressure, and records its
    // report once the transaction is accepted.
    task automatic send_event(input item_t ev, input bit typed, input result_t want);
        result_t rep;
        while (!calm_stretch && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, ev.direction, ev.floor, ev.position};
        s_axis_tuser <= ev.mode;
        do
            @(posedge clk);
        while (!s_axis_tready);
        rep = advance_monitor(ev);
        pending_reports.push_back(typed ? want : rep);
    endtask

    // Tolerance writes happen only with the pipeline drained.
    task automatic write_tolerance(input logic [15:0] value);
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_reports.size() != 0);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        tolerance = value;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // The result side stalls at random except during the calm stretch.
    always @(posedge clk)
        m_axis_tready <= calm_stretch || ($urandom_range(0, 99) >= IDLE_PERCENT);

    // Each result transaction is matched against the oldest pending report.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_reports.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("monitor_state", want.monitor_state, m_axis_tdata[1:0]);
                check_field("issue_raised", want.issue_raised, m_axis_tdata[2]);
                check_field("limits_locked", want.limits_locked, m_axis_tdata[3]);
                check_field("checking", want.checking, m_axis_tdata[4]);
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("travel_limit_window_monitor_top test failed");
        $finish;
    end

    initial
    begin
        logic [15:0] phase_tol[5];
        item_t       ev;
        result_t     none;

        tolerance = TOLERANCE_RESET;
        st_state = ST_WAIT;
        st_armed = 1'b0;
        st_notified = 1'b0;
        st_check_en = 1'b0;
        seen_bottom = 1'b0;
        seen_top = 1'b0;
        cap_bottom = '0;
        cap_top = '0;
        lim_lo = '0;
        lim_hi = '0;
        lim_locked = 1'b0;
        none = '0;

        // Directed walk. The bottom endstop is captured above the top one so the
        // limits have to be sorted: the window becomes -1000 .. 5000. Equal
        // captures would leave the window unlocked for good, and reset is
        // applied only once, so the run locks distinct limits instead.
        add_row(MODE_TICK, 0, 0, DIR_UP, 1, ST_WAIT, 0, 0, 0);
        add_row(MODE_SPARE6, 32'sh7fffffff, 15, DIR_SPARE, 1, ST_WAIT, 0, 0, 0);
        add_row(MODE_SPARE7, 32'sh80000000, 0, DIR_UP, 1, ST_WAIT, 0, 0, 0);
        add_row(MODE_ERROR, 0, 0, DIR_UP, 1, ST_WAIT, 0, 0, 0);
        add_row(MODE_STARTED, 0, 0, DIR_UP, 1, ST_MON, 0, 0, 0);
        add_row(MODE_TICK, 32'sh7fffffff, 0, DIR_SPARE, 1, ST_MON, 0, 0, 0);
        add_row(MODE_ERROR, 0, 0, DIR_UP, 1, ST_ERR, 1, 0, 0);
        add_row(MODE_ERROR, 0, 0, DIR_UP, 1, ST_ERR, 0, 0, 0);
        add_row(MODE_DISARM, 0, 0, DIR_UP, 1, ST_ERR, 0, 0, 0);
        add_row(MODE_ARM, 0, 0, DIR_UP, 1, ST_WAIT, 0, 0, 0);
        add_row(MODE_REACHED, 32'sh80000000, 15, DIR_UP, 1, ST_WAIT, 0, 0, 0);
        add_row(MODE_REACHED, 5000, FLOOR_BOTTOM, DIR_UP, 0, ST_WAIT, 0, 0, 0);
        add_row(MODE_STARTED, 0, 0, DIR_UP, 0, ST_WAIT, 0, 0, 0);
        add_row(MODE_TICK, 32'sh80000000, 0, DIR_SPARE, 0, ST_WAIT, 0, 0, 0);
        add_row(MODE_REACHED, -1000, FLOOR_TOP, DIR_DOWN, 0, ST_WAIT, 0, 0, 0);
        add_row(MODE_REACHED, 0, FLOOR_BOTTOM, DIR_UP, 0, ST_WAIT, 0, 0, 0);
        add_row(MODE_STARTED, 0, 0, DIR_UP, 0, ST_WAIT, 0, 0, 0);
        add_row(MODE_TICK, 5015, 0, DIR_UP, 0, ST_WAIT, 0, 0, 0);
        add_row(MODE_TICK, -1015, 0, DIR_DOWN, 0, ST_WAIT, 0, 0, 0);
        add_row(MODE_TICK, 5015, 0, DIR_UNKNOWN, 0, ST_WAIT, 0, 0, 0);
        add_row(MODE_TICK, 32'sh7fffffff, 0, DIR_DOWN, 0, ST_WAIT, 0, 0, 0);
        add_row(MODE_TICK, -1016, 0, DIR_SPARE, 0, ST_WAIT, 0, 0, 0);
        add_row(MODE_TICK, 5016, 0, DIR_UP, 0, ST_WAIT, 0, 0, 0);
        add_row(MODE_ARM, 0, 0, DIR_UP, 0, ST_WAIT, 0, 0, 0);
        add_row(MODE_DISARM, 0, 0, DIR_UP, 0, ST_WAIT, 0, 0, 0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);

        // Random phases, each under its own tolerance, the extremes included.
        phase_tol[0] = 16'd0;
        phase_tol[1] = 16'hffff;
        phase_tol[2] = 16'($urandom_range(2, 65534));
        phase_tol[3] = 16'd1;
        phase_tol[4] = TOLERANCE_RESET;
        for (int phase = 0; phase < 5; phase++)
        begin
            write_tolerance(phase_tol[phase]);
            calm_stretch <= (phase == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                ev = pick_event();
                send_event(ev, 1'b0, none);
            end
        end
        calm_stretch <= 1'b0;
        s_axis_tvalid <= 1'b0;

        // Drain the outstanding reports, then give the pipeline time to show any
        // stray result.
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (fail_count == 0)
            $display("travel_limit_window_monitor_top test passed");
        else
            $display("travel_limit_window_monitor_top test failed");
        $finish;
    end

endmodule
